/* src/cclf_pkg.sv */
// Shared types, character codes and helpers for the checksummed command line framer.
// No dependencies; imported by checksummed_command_line_framer.
`default_nettype none

package cclf_pkg;

	localparam int unsigned LINE_CAPACITY_DEF = 96;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [15:0] SEQ_MAX = 16'hFFFF;

	// frame_status codes
	localparam logic [1:0] FS_OK       = 2'd0;
	localparam logic [1:0] FS_FORMAT   = 2'd1;
	localparam logic [1:0] FS_CHECKSUM = 2'd2;

	// command_kind codes
	localparam logic [1:0] CK_UNKNOWN = 2'd0;
	localparam logic [1:0] CK_SETALL  = 2'd1;
	localparam logic [1:0] CK_RUN     = 2'd2;

	// Prefix matcher: one state per matched character of "SETALL " or "RUN "
	typedef enum logic [3:0] {
		PS_START    = 4'd0,
		PS_S        = 4'd1,
		PS_SE       = 4'd2,
		PS_SET      = 4'd3,
		PS_SETA     = 4'd4,
		PS_SETAL    = 4'd5,
		PS_SETALL   = 4'd6,
		PS_SET_DONE = 4'd7,
		PS_R        = 4'd8,
		PS_RU       = 4'd9,
		PS_RUN      = 4'd10,
		PS_RUN_DONE = 4'd11,
		PS_FAIL     = 4'd12
	} prefix_t;

	// "SEQ:" marker search and decimal extraction
	typedef enum logic [2:0] {
		MS_SEARCH = 3'd0,
		MS_S      = 3'd1,
		MS_SE     = 3'd2,
		MS_SEQ    = 3'd3,
		MS_FOUND  = 3'd4,
		MS_DIGITS = 3'd5,
		MS_DONE   = 3'd6
	} marker_t;

	// Character expected next from a partial prefix match
	function automatic logic [7:0] prefix_char(prefix_t s);
		logic [7:0] c;
		c = 8'h00;
		case (s)
			PS_S:     c = "E";
			PS_SE:    c = "T";
			PS_SET:   c = "A";
			PS_SETA:  c = "L";
			PS_SETAL: c = "L";
			PS_SETALL: c = " ";
			PS_R:     c = "U";
			PS_RU:    c = "N";
			PS_RUN:   c = " ";
			default:  c = 8'h00;
		endcase
		return c;
	endfunction

	// Character expected next from a partial marker match
	function automatic logic [7:0] marker_char(marker_t s);
		logic [7:0] c;
		c = 8'h00;
		case (s)
			MS_SEARCH: c = "S";
			MS_S:      c = "E";
			MS_SE:     c = "Q";
			MS_SEQ:    c = ":";
			default:   c = 8'h00;
		endcase
		return c;
	endfunction

	// {bad, nibble}: bad is set for anything that is not a hex digit
	function automatic logic [4:0] hex_nibble(logic [7:0] c);
		logic [4:0] r;
		r = 5'h10;
		if (c >= "0" && c <= "9")
			r = {1'b0, 4'(c - 8'h30)};
		else if (c >= "A" && c <= "F")
			r = {1'b0, 4'(c - 8'h37)};
		else if (c >= "a" && c <= "f")
			r = {1'b0, 4'(c - 8'h57)};
		return r;
	endfunction

endpackage

`default_nettype wire

/* src/checksummed_command_line_framer.sv */
// A newline byte goes into the input register; its result then loads into the result register.
// Throughput: one byte per cycle; a byte in the input register stalls while a result sits in
// the result register with res_stall high, whether or not that byte is a newline.
// Reset (arst_n low, asynchronous) empties both registers and returns the line state
// to start of line; a newline does the same for the line state. Depends on cclf_pkg.
`default_nettype none

module checksummed_command_line_framer #(
	parameter int unsigned LINE_CAPACITY = cclf_pkg::LINE_CAPACITY_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        rx_valid,
	output logic             rx_stall,
	input  wire logic [7:0]  rx_byte,
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic [1:0]       frame_status,
	output logic [1:0]       command_kind,
	output logic [15:0]      sequence_number
);
	import cclf_pkg::*;

	localparam int unsigned LEN_W = $clog2(LINE_CAPACITY);
	localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_CAPACITY - 1);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// line state
	logic [LEN_W-1:0] len_q, len_d;
	logic             ovf_q, ovf_d;
	logic [7:0]       xor_q, xor_d;
	logic [7:0]       xor_star_q, xor_star_d;
	logic             star_q, star_d;
	logic [1:0]       after_q, after_d;
	logic [7:0]       digits_q, digits_d;
	logic             digit_bad_q, digit_bad_d;
	prefix_t          ps_q, ps_d;
	marker_t          ms_q, ms_d;
	logic [15:0]      seq_q, seq_d;

	// result register
	logic        res_valid_q;
	logic [1:0]  status_q, kind_q;
	logic [15:0] seq_out_q;

	logic        out_free, fire_s1, is_cr, is_lf, emit;
	logic        is_digit;
	logic [3:0]  digit_val;
	logic [4:0]  hex;
	logic [19:0] seq_next;
	logic [1:0]  kind_c, status_c;

	assign out_free = !res_valid_q || !res_stall;
	assign fire_s1  = valid_s1 && out_free;
	assign rx_stall = valid_s1 && !out_free;

	assign is_cr     = (byte_s1 == CH_CR);
	assign is_lf     = (byte_s1 == CH_LF);
	assign emit      = fire_s1 && is_lf && (ovf_q || (len_q != '0));
	assign is_digit  = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
	assign digit_val = 4'(byte_s1 - CH_ZERO);
	assign hex       = hex_nibble(byte_s1);
	assign seq_next  = 20'(seq_q) * 20'd10 + 20'(digit_val);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_valid && !rx_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	// Result of the line held in the state registers
	always_comb begin
		kind_c = CK_UNKNOWN;
		if (ps_q == PS_SET_DONE)
			kind_c = CK_SETALL;
		else if (ps_q == PS_RUN_DONE)
			kind_c = CK_RUN;
		if (!star_q || after_q != 2'd2 || digit_bad_q)
			status_c = FS_FORMAT;
		else if (xor_star_q != digits_q)
			status_c = FS_CHECKSUM;
		else if (kind_c == CK_UNKNOWN)
			status_c = FS_FORMAT;
		else
			status_c = FS_OK;
	end

	// Next line state
	always_comb begin
		len_d       = len_q;
		ovf_d       = ovf_q;
		xor_d       = xor_q;
		xor_star_d  = xor_star_q;
		star_d      = star_q;
		after_d     = after_q;
		digits_d    = digits_q;
		digit_bad_d = digit_bad_q;
		ps_d        = ps_q;
		ms_d        = ms_q;
		seq_d       = seq_q;
		if (fire_s1 && !is_cr) begin
			if (is_lf) begin
				len_d       = '0;
				ovf_d       = 1'b0;
				xor_d       = '0;
				xor_star_d  = '0;
				star_d      = 1'b0;
				after_d     = '0;
				digits_d    = '0;
				digit_bad_d = 1'b0;
				ps_d        = PS_START;
				ms_d        = MS_SEARCH;
				seq_d       = '0;
			end else if (len_q < LEN_LIMIT) begin
				len_d = len_q + 1'b1;

				unique case (ps_q)
					PS_START: begin
						if (byte_s1 == "S")
							ps_d = PS_S;
						else if (byte_s1 == "R")
							ps_d = PS_R;
						else
							ps_d = PS_FAIL;
					end
					PS_S, PS_SE, PS_SET, PS_SETA, PS_SETAL, PS_SETALL,
					PS_R, PS_RU, PS_RUN: begin
						ps_d = (byte_s1 == prefix_char(ps_q)) ?
							prefix_t'(4'(ps_q) + 4'd1) : PS_FAIL;
					end
					PS_SET_DONE, PS_RUN_DONE, PS_FAIL: begin
						ps_d = ps_q;
					end
					default: begin
						ps_d = PS_FAIL;
					end
				endcase

				unique case (ms_q)
					MS_SEARCH, MS_S, MS_SE, MS_SEQ: begin
						if (byte_s1 == marker_char(ms_q)) begin
							ms_d  = marker_t'(3'(ms_q) + 3'd1);
							seq_d = '0;
						end else begin
							ms_d = (byte_s1 == "S") ? MS_S : MS_SEARCH;
						end
					end
					MS_FOUND: begin
						if (is_digit) begin
							seq_d = 16'(digit_val);
							ms_d  = MS_DIGITS;
						end else begin
							seq_d = '0;
							ms_d  = MS_DONE;
						end
					end
					MS_DIGITS: begin
						if (!is_digit) begin
							ms_d = MS_DONE;
						end else if (seq_next > 20'(SEQ_MAX)) begin
							seq_d = '0;
							ms_d  = MS_DONE;
						end else begin
							seq_d = seq_next[15:0];
						end
					end
					MS_DONE: begin
						ms_d = MS_DONE;
					end
					default: begin
						ms_d = MS_DONE;
					end
				endcase

				// checksum field follows the last '*'
				if (byte_s1 == CH_STAR) begin
					xor_star_d  = xor_q;
					star_d      = 1'b1;
					after_d     = '0;
					digits_d    = '0;
					digit_bad_d = 1'b0;
				end else if (star_q) begin
					if (after_q < 2'd2) begin
						if (hex[4])
							digit_bad_d = 1'b1;
						else
							digits_d = {digits_q[3:0], hex[3:0]};
						after_d = after_q + 2'd1;
					end else begin
						after_d = 2'd3;
					end
				end
				xor_d = xor_q ^ byte_s1;
			end else begin
				ovf_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			ovf_q       <= 1'b0;
			xor_q       <= '0;
			xor_star_q  <= '0;
			star_q      <= 1'b0;
			after_q     <= '0;
			digits_q    <= '0;
			digit_bad_q <= 1'b0;
			ps_q        <= PS_START;
			ms_q        <= MS_SEARCH;
			seq_q       <= '0;
		end else begin
			len_q       <= len_d;
			ovf_q       <= ovf_d;
			xor_q       <= xor_d;
			xor_star_q  <= xor_star_d;
			star_q      <= star_d;
			after_q     <= after_d;
			digits_q    <= digits_d;
			digit_bad_q <= digit_bad_d;
			ps_q        <= ps_d;
			ms_q        <= ms_d;
			seq_q       <= seq_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (ovf_q) begin
				status_q  <= FS_FORMAT;
				kind_q    <= CK_UNKNOWN;
				seq_out_q <= '0;
			end else begin
				status_q  <= status_c;
				kind_q    <= kind_c;
				seq_out_q <= seq_q;
			end
		end
	end

	assign res_valid       = res_valid_q;
	assign frame_status    = status_q;
	assign command_kind    = kind_q;
	assign sequence_number = seq_out_q;

`ifndef SYNTHESIS
	a_len_limit: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_LIMIT)
		else $error("line length beyond capacity");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> len_q == LEN_LIMIT)
		else $error("overflow flagged on a line that is not full");

	a_after_needs_star: assert property (@(posedge clk) disable iff (!arst_n)
		(after_q != 2'd0 || digit_bad_q) |-> star_q)
		else $error("check field progress without a star");

	a_ok_has_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && status_q == FS_OK) |-> kind_q != CK_UNKNOWN)
		else $error("ok result without a known command");

	a_emit_after_lf: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (len_q == '0 && !ovf_q && !star_q && ps_q == PS_START))
		else $error("line state not cleared after newline");
`endif

endmodule

`default_nettype wire
